[hdl/rpr_pkg.sv]
// ---------------------------------------------------------------------------
// rpr_pkg
// Shared widths and status codes for the rational power / exact root unit.
// ---------------------------------------------------------------------------
package rpr_pkg;
  localparam int DEF_DATA_WIDTH = 64;
  localparam int EXP_W = 64;
  localparam int DEN_W = 63;
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] ST_OK   = 3'd0;
  localparam logic [ST_W-1:0] ST_BASE = 3'd1;
  localparam logic [ST_W-1:0] ST_ZDEN = 3'd2;
  localparam logic [ST_W-1:0] ST_NEG  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVF  = 3'd4;
endpackage

[hdl/rpr_if.sv]
// ---------------------------------------------------------------------------
// rpr_in_if / rpr_out_if
// Valid/ready channels carrying operand and result beats.
// ---------------------------------------------------------------------------
interface rpr_in_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] base_value;
  logic [63:0]  exp_numer;
  logic [62:0]  exp_denom;
  modport source(output valid, base_value, exp_numer, exp_denom, input ready);
  modport sink(input valid, base_value, exp_numer, exp_denom, output ready);
endinterface

interface rpr_out_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] value_numer;
  logic [62:0]  value_denom;
  logic [2:0]   status;
  modport source(output valid, value_numer, value_denom, status, input ready);
  modport sink(input valid, value_numer, value_denom, status, output ready);
endinterface

[hdl/rpr_mul.sv]
// ---------------------------------------------------------------------------
// rpr_mul
// Shared checked multiplier: product of two W-bit words, 16x16 partial
// products one per cycle, with a flag when the product exceeds W bits.
// ---------------------------------------------------------------------------
module rpr_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] prod,
  output logic         ovf
);
  localparam int PW = 2*W + 32;
  localparam int NC = (W + 15) / 16;
  localparam int IW = (NC > 1) ? $clog2(NC) : 1;

  logic [W-1:0]  ra, rb;
  logic [PW-1:0] acc;
  logic          busy;
  logic [IW-1:0] ia, ib;
  logic [15:0]   da, db;
  logic [31:0]   dp;
  logic [PW-1:0] pp;
  logic [2*W+15:0] ea, eb;

  assign ea = {{(W+16){1'b0}}, ra} >> (ia * 16);
  assign eb = {{(W+16){1'b0}}, rb} >> (ib * 16);
  assign da = ea[15:0];
  assign db = eb[15:0];
  assign dp = {16'd0, da} * {16'd0, db};
  assign pp = PW'(dp) << ((ia + ib) * 16);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      ra <= a; rb <= b; acc <= '0; ia <= '0; ib <= '0; busy <= 1'b1;
    end else if (busy) begin
      acc <= acc + pp;
      if (ib == IW'(NC - 1)) begin
        ib <= '0;
        if (ia == IW'(NC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          ia <= ia + 1'b1;
        end
      end else begin
        ib <= ib + 1'b1;
      end
    end
  end

  always_comb begin
    prod = acc[W-1:0];
    ovf  = |acc[PW-1:W];
  end
endmodule

[hdl/rpr_div.sv]
// ---------------------------------------------------------------------------
// rpr_div
// Restoring divider, one quotient bit per cycle; used for gcd remainders
// and the final reduction.
// ---------------------------------------------------------------------------
module rpr_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q, r, dd;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    sh;

  assign sh = {r, q[W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      q <= n; r <= '0; dd <= d; cnt <= '0; busy <= 1'b1;
    end else if (busy) begin
      if (sh >= {1'b0, dd}) begin
        r <= W'(sh - {1'b0, dd});
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= sh[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = q;
  assign rem = r;
endmodule

[hdl/rational_power_with_exact_root_unit.sv]
// ---------------------------------------------------------------------------
// rational_power_with_exact_root_unit
// Checked p^a, b-th root search, exact-root test and gcd reduction.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | base_value, exp_numer, exp_denom
//  out     | out | value_numer, value_denom, status
//
//  One beat at a time. Run time depends on the operands: a power takes up
//  to two checked multiplies on the shared multiplier per exponent bit and
//  stops at the first overflow, the root search up to W powers, the gcd up
//  to ~93 remainder steps on the 64-bit divider. in.ready is low while busy.
//  Reset (rst, synchronous) returns the sequencer to idle; out holds a beat
//  until taken.
module rational_power_with_exact_root_unit
  import rpr_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  rpr_in_if.sink   in,
  rpr_out_if.source out
);
  localparam int W  = DATA_WIDTH;
  localparam int GW = EXP_W;

  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_PW_BIT = 4'd2,
    S_PW_MA = 4'd3, S_PW_SQ = 4'd4, S_AFTER = 4'd5, S_RT_MID = 4'd6,
    S_RT_CMP = 4'd7, S_GCD = 4'd9, S_GCD_W = 4'd10,
    S_RED_N = 4'd11, S_RED_D = 4'd12, S_OUT = 4'd13;
  localparam logic [1:0] P_MAIN = 2'd0, P_ROOT = 2'd1, P_EXACT = 2'd2;

  logic [3:0]   state;
  logic [1:0]   purpose;
  logic [63:0]  p, a;
  logic [62:0]  b;
  logic [W-1:0] pa, lo, hi, mid;
  logic [W-1:0] pb, pacc;
  logic [63:0]  pe;
  logic         povf;
  logic [GW-1:0] gx, gy;

  logic         m_start, m_done, m_ovf;
  logic [W-1:0] m_a, m_b, m_prod;
  logic          d_start, d_done;
  logic [GW-1:0] d_n, d_d, d_q, d_r;

  logic [W-1:0] onum;
  logic [62:0]  oden;
  logic [2:0]   ost;

  rpr_mul #(.W(W)) u_mul (.clk, .rst, .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_prod), .ovf(m_ovf));
  rpr_div #(.W(GW)) u_div (.clk, .rst, .start(d_start), .n(d_n), .d(d_d),
    .done(d_done), .quo(d_q), .rem(d_r));

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.value_numer = onum;
  assign out.value_denom = oden;
  assign out.status = ost;

  task automatic pw_begin(input logic [W-1:0] base, input logic [63:0] e,
                          input logic [1:0] why);
    begin
      purpose <= why;
      pb <= base; pe <= e; pacc <= W'(1); povf <= 1'b0;
      state <= S_PW_BIT;
    end
  endtask

  always_ff @(posedge clk) begin
    m_start <= 1'b0;
    d_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            p <= 64'(in.base_value); a <= in.exp_numer; b <= in.exp_denom;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          onum <= '0; oden <= 63'd1; ost <= ST_OK;
          if (p < 64'd2) begin
            ost <= ST_BASE; state <= S_OUT;
          end else if (b == '0) begin
            ost <= ST_ZDEN; state <= S_OUT;
          end else if (a[63]) begin
            ost <= ST_NEG; state <= S_OUT;
          end else if (a == '0) begin
            onum <= W'(1); state <= S_OUT;
          end else begin
            pw_begin(p[W-1:0], a, P_MAIN);
          end
        end
        S_PW_BIT: begin
          // zero-exponent and base<=1 short cuts of the checked power
          if (pe == '0 || pb <= W'(1)) begin
            if (pe != '0) pacc <= pb;
            state <= S_AFTER;
          end else if (pe[0]) begin
            m_a <= pacc; m_b <= pb; m_start <= 1'b1; state <= S_PW_MA;
          end else begin
            pe <= pe >> 1;
            m_a <= pb; m_b <= pb; m_start <= 1'b1; state <= S_PW_SQ;
          end
        end
        S_PW_MA: begin
          if (m_done) begin
            if (m_ovf) begin
              povf <= 1'b1; state <= S_AFTER;
            end else begin
              pacc <= m_prod;
              pe <= pe >> 1;
              if ((pe >> 1) == '0) begin
                state <= S_AFTER;
              end else begin
                m_a <= pb; m_b <= pb; m_start <= 1'b1; state <= S_PW_SQ;
              end
            end
          end
        end
        S_PW_SQ: begin
          if (m_done) begin
            if (m_ovf) begin
              povf <= 1'b1; state <= S_AFTER;
            end else begin
              pb <= m_prod; pe <= pe; state <= S_PW_BIT;
            end
          end
        end
        S_AFTER: begin
          case (purpose)
            P_MAIN: begin
              if (povf || (W < 64 && (p >> W) != 64'd0)) begin
                ost <= ST_OVF; state <= S_OUT;
              end else if (b == 63'd1) begin
                onum <= pacc; state <= S_OUT;
              end else begin
                pa <= pacc;
                lo <= W'(1); hi <= pacc;
                state <= S_RT_MID;
              end
            end
            P_ROOT: begin
              if (!povf && pacc <= pa) lo <= mid;
              else hi <= mid - W'(1);
              state <= S_RT_MID;
            end
            default: begin
              if (!povf && pacc == pa) begin
                onum <= lo; state <= S_OUT;
              end else begin
                gx <= GW'(pa); gy <= {1'b0, b}; state <= S_GCD;
              end
            end
          endcase
        end
        S_RT_MID: begin
          if (pa <= W'(1)) begin
            lo <= pa; pw_begin(pa, 64'(b), P_EXACT);
          end else if (lo < hi) begin
            mid <= lo + ((hi - lo + W'(1)) >> 1);
            state <= S_RT_CMP;
          end else begin
            pw_begin(lo, 64'(b), P_EXACT);
          end
        end
        S_RT_CMP: pw_begin(mid, 64'(b), P_ROOT);
        S_GCD: begin
          if (gy == '0) begin
            d_n <= GW'(pa); d_d <= gx; d_start <= 1'b1; state <= S_RED_N;
          end else begin
            d_n <= gx; d_d <= gy; d_start <= 1'b1; state <= S_GCD_W;
          end
        end
        S_GCD_W: if (d_done) begin gx <= gy; gy <= d_r; state <= S_GCD; end
        S_RED_N: begin
          if (d_done) begin
            onum <= W'(d_q);
            d_n <= {1'b0, b}; d_d <= gx; d_start <= 1'b1; state <= S_RED_D;
          end
        end
        S_RED_D: if (d_done) begin oden <= 63'(d_q); state <= S_OUT; end
        S_OUT: if (out.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/rpr_checker.sv]
// ---------------------------------------------------------------------------
// rpr_checker
// Port-level checks of the rational power unit, bound to the top level.
// ---------------------------------------------------------------------------
module rpr_checker
  import rpr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [62:0] value_denom,
  input logic [2:0]  status,
  input logic [63:0] value_numer
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open while result pending");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK && status != ST_OVF |->
      value_numer == '0 && value_denom == 63'd1)
    else $error("error result not 0/1");
  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value_denom != '0) else $error("zero denominator out");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
endmodule

bind rational_power_with_exact_root_unit rpr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .value_denom(out.value_denom), .status(out.status),
  .value_numer(64'(out.value_numer)));

[tb/rpr_tb_if.sv]
// ---------------------------------------------------------------------------
// rpr_tb_if
// Testbench-side struct types for the operand and result channels.
// ---------------------------------------------------------------------------
package rpr_tb_pkg;
  import rpr_pkg::*;

  typedef struct packed {
    logic [63:0]      numer;
    logic [DEN_W-1:0] denom;
    logic [ST_W-1:0]  status;
  } rpr_result_t;

  typedef struct packed {
    logic [63:0]      base_value;
    logic [63:0]      exp_numer;
    logic [DEN_W-1:0] exp_denom;
  } rpr_operand_t;
endpackage

[tb/tb_rational_power_with_exact_root_unit.sv]
// ---------------------------------------------------------------------------
// tb_rational_power_with_exact_root_unit
// Self-checking bench: directed operand table, then random operands, every
// result beat compared against the table's expected result or an in-bench model of p^(a/b).
// ---------------------------------------------------------------------------
module tb_rational_power_with_exact_root_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rpr_pkg::*;
  import rpr_tb_pkg::*;

  localparam int W          = DEF_DATA_WIDTH;
  localparam int N_RANDOM   = 118;
  localparam int CYCLE_CAP  = 20000000;
  localparam logic [63:0] VAL_MAX = {64{1'b1}} >> (64 - W);

  typedef struct {
    rpr_operand_t op;
    bit           typed;
    rpr_result_t  res;
  } dir_row_t;

  logic clk;
  logic rst;
  int   n_err;
  int   cycles = 0;
  bit   calm;
  bit   hold_req;
  bit   hold;

  rpr_result_t  pending_q[$];
  dir_row_t     dir_tab[$];

  rpr_in_if  #(.W(W)) in_bus ();
  rpr_out_if #(.W(W)) out_bus ();

  rational_power_with_exact_root_unit #(.DATA_WIDTH(W)) u_dut (
    .clk(clk),
    .rst(rst),
    .in (in_bus),
    .out(out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** rational_power_with_exact_root_unit: FAILED **");
      $finish;
    end
  end

  // ---- model of the block ----
  function automatic bit pow_fits(input logic [63:0] b_in, input logic [63:0] e_in,
                                  output logic [63:0] res);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] e;
    acc = 64'd1;
    b   = b_in;
    e   = e_in;
    res = 64'd0;
    if (e == 0) begin
      res = 64'd1;
      return 1'b1;
    end
    if (b <= 1) begin
      res = b;
      return 1'b1;
    end
    while (e > 0) begin
      if (e[0]) begin
        if (acc > VAL_MAX / b) return 1'b0;
        acc = acc * b;
      end
      e = e >> 1;
      if (e > 0) begin
        if (b > VAL_MAX / b) return 1'b0;
        b = b * b;
      end
    end
    res = acc;
    return 1'b1;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v, input logic [63:0] n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] pw;
    lo = 64'd1;
    hi = v;
    if (n == 0) return 64'd1;
    if (n == 1 || v <= 1) return v;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 2;
      if (pow_fits(mid, n, pw) && pw <= v) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x_in, input logic [63:0] y_in);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    x = x_in;
    y = y_in;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rpr_result_t rational_power(input rpr_operand_t op);
    rpr_result_t r;
    logic [63:0] b;
    logic [63:0] pa;
    logic [63:0] chk;
    logic [63:0] rt;
    logic [63:0] g;
    b = {1'b0, op.exp_denom};
    r.numer  = 64'd0;
    r.denom  = 63'd1;
    r.status = ST_OK;
    if (op.base_value < 2) r.status = ST_BASE;
    else if (b == 0) r.status = ST_ZDEN;
    else if (op.exp_numer[63]) r.status = ST_NEG;
    else if (op.exp_numer == 0) r.numer = 64'd1;
    else if (op.base_value > VAL_MAX || !pow_fits(op.base_value, op.exp_numer, pa))
      r.status = ST_OVF;
    else if (b == 1) r.numer = pa;
    else begin
      rt = root_floor(pa, b);
      if (pow_fits(rt, b, chk) && chk == pa) r.numer = rt;
      else begin
        g = gcd64(pa, b);
        if (g == 0) g = 64'd1;
        r.numer = pa / g;
        r.denom = 63'(b / g);
      end
    end
    return r;
  endfunction

  // ---- result checking ----
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH t=%0t %s: got %0h expected %0h", $time, what, got, want);
    n_err++;
  endtask

  // long receiver stall, counted here
  initial begin
    hold = 1'b0;
    wait (hold_req);
    hold = 1'b1;
    repeat (400) @(posedge clk);
    hold = 1'b0;
  end

  initial begin
    rpr_result_t want;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_bus.valid && out_bus.ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected beat", out_bus.value_numer, 64'd0);
        end else begin
          want = pending_q.pop_front();
          if (out_bus.value_numer !== want.numer)
            report_mismatch("value_numer", out_bus.value_numer, want.numer);
          if (out_bus.value_denom !== want.denom)
            report_mismatch("value_denom", {1'b0, out_bus.value_denom}, {1'b0, want.denom});
          if (out_bus.status !== want.status)
            report_mismatch("status", 64'(out_bus.status), 64'(want.status));
        end
      end
      if (hold) begin
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // ---- stimulus ----
  task automatic send_beat(input rpr_operand_t op, input bit typed, input rpr_result_t res);
    in_bus.valid      <= 1'b1;
    in_bus.base_value <= op.base_value[W-1:0];
    in_bus.exp_numer  <= op.exp_numer;
    in_bus.exp_denom  <= op.exp_denom;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_q.push_back(typed ? res : rational_power(op));
    if (!calm && $urandom_range(99) < 29) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic void add_row(input logic [63:0] p, input logic [63:0] a,
                                  input logic [62:0] b, input bit typed,
                                  input logic [63:0] n, input logic [62:0] d,
                                  input logic [2:0] st);
    dir_row_t row;
    row.op.base_value = p;
    row.op.exp_numer  = a;
    row.op.exp_denom  = b;
    row.typed         = typed;
    row.res.numer     = n;
    row.res.denom     = d;
    row.res.status    = st;
    dir_tab.push_back(row);
  endfunction

  function automatic rpr_operand_t random_operand();
    rpr_operand_t op;
    int mode;
    int b;
    mode = $urandom_range(99);
    b    = $urandom_range(1, 6);
    op.base_value = 64'($urandom_range(2, 20));
    op.exp_denom  = 63'(b);
    if ($urandom_range(1)) op.exp_numer = 64'(b * $urandom_range(1, 4));
    else op.exp_numer = 64'($urandom_range(0, 12));
    if (mode >= 60 && mode < 70) begin
      op.base_value = 64'($urandom_range(2, 1000));
      op.exp_denom  = 63'($urandom_range(2, 4));
      op.exp_numer  = {1'b0, op.exp_denom};
    end else if (mode >= 70 && mode < 80) begin
      op.base_value = {32'd0, 32'($urandom)} | 64'd2;
      op.exp_numer  = 64'($urandom_range(1, 4));
      op.exp_denom  = 63'($urandom_range(1, 3));
    end else if (mode >= 80) begin
      op.base_value = {32'($urandom), 32'($urandom)};
      op.exp_numer  = {32'($urandom), 32'($urandom)};
      op.exp_denom  = {31'($urandom), 32'($urandom)};
      if (mode >= 95) op.base_value = 64'($urandom_range(1));
      else if (mode >= 90) op.exp_denom = '0;
    end
    return op;
  endfunction

  initial begin
    rpr_result_t none;
    rst                = 1'b1;
    n_err              = 0;
    calm               = 1'b0;
    hold_req           = 1'b0;
    none               = '0;
    in_bus.valid       = 1'b0;
    in_bus.base_value  = '0;
    in_bus.exp_numer   = '0;
    in_bus.exp_denom   = '0;

    // errors in priority order, zero exponent, overflow, extremes
    add_row(64'd0, 64'd1, 63'd1, 1, 64'd0, 63'd1, ST_BASE);
    add_row(64'd1, 64'd5, 63'd0, 1, 64'd0, 63'd1, ST_BASE);
    add_row(64'd0, 64'h8000_0000_0000_0000, 63'd0, 1, 64'd0, 63'd1, ST_BASE);
    add_row(64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 1, 64'd0, 63'd1, ST_ZDEN);
    add_row(64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 63'd5, 1, 64'd0, 63'd1, ST_NEG);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, {63{1'b1}}, 1,
            64'd0, 63'd1, ST_NEG);
    add_row(64'd5, 64'd0, 63'd7, 1, 64'd1, 63'd1, ST_OK);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, {63{1'b1}}, 1, 64'd1, 63'd1, ST_OK);
    add_row(64'd2, 64'd64, 63'd1, 1, 64'd0, 63'd1, ST_OVF);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 63'd1, 1, 64'd0, 63'd1, ST_OVF);
    add_row(64'd2, 64'h7FFF_FFFF_FFFF_FFFF, 63'd3, 1, 64'd0, 63'd1, ST_OVF);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 63'd1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 63'd1, ST_OK);
    add_row(64'd2, 64'd63, 63'd1, 1, 64'h8000_0000_0000_0000, 63'd1, ST_OK);
    add_row(64'd4, 64'd3, 63'd2, 1, 64'd8, 63'd1, ST_OK);
    add_row(64'd2, 64'd62, 63'd62, 1, 64'd2, 63'd1, ST_OK);
    // inexact roots, unreduced exponent, wide denominators
    add_row(64'd2, 64'd3, 63'd2, 0, 0, 0, 0);
    add_row(64'd2, 64'd63, 63'd2, 0, 0, 0, 0);
    add_row(64'd3, 64'd1, {63{1'b1}}, 0, 0, 0, 0);
    add_row(64'd6, 64'd4, 63'd6, 0, 0, 0, 0);
    add_row(64'd9, 64'd2, 63'd4, 0, 0, 0, 0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 63'd3, 0, 0, 0, 0);
    add_row(64'hFFFF_FFFF_FFFF_FFFB, 64'd1, 63'd2, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= 30 && i < 50);
      if (i == 60) hold_req = 1'b1;
      if (i == 100) begin
        in_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      send_beat(random_operand(), 1'b0, none);
    end
    in_bus.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_err == 0) begin
      $display("** rational_power_with_exact_root_unit: PASSED **");
    end else begin
      $display("** rational_power_with_exact_root_unit: FAILED **");
    end
    $finish;
  end
endmodule

[files.f]
hdl/rpr_pkg.sv
hdl/rpr_if.sv
hdl/rpr_mul.sv
hdl/rpr_div.sv
hdl/rational_power_with_exact_root_unit.sv
hdl/rpr_checker.sv
tb/rpr_tb_if.sv
tb/tb_rational_power_with_exact_root_unit.sv
